[design/adx_block_framer_defines.svh]
// Assertion macros used by the block framer core
`ifndef ADX_BLOCK_FRAMER_DEFINES_SVH
`define ADX_BLOCK_FRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define ADXBF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define ADXBF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/adxbf_pkg.sv]
// Types and constants of the block framer
package adxbf_pkg;

	localparam logic [63:0] HdrMask    = 64'hFFFF_0000_FFFF_FF00;
	localparam logic [63:0] HdrPattern = 64'h8000_0000_0312_0400;

	localparam int CntW = 17;
	typedef logic [CntW-1:0] cnt_t;

	localparam cnt_t HdrLenAdj = 17'd4;  // header length field excludes the leading 4 bytes
	localparam cnt_t MinHdrLen = 17'd8;
	localparam cnt_t HdrLead   = 17'd7;  // header start lies 7 bytes before the match byte

	localparam logic [7:0] BlockUnitReset = 8'd18;

	localparam int AddrW = 3;
	typedef enum logic {
		REG_BLOCK_UNIT = 1'b0
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
	} raw_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_last;
		logic       locked;
	} framed_item_t;

	typedef struct packed {
		logic frame_last;
		logic locked;
	} status_t;

endpackage

[design/adxbf_stream_if.sv]
// Valid/ready stream channel
interface adxbf_stream_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/adxbf_core.sv]
// Header search, lock and frame countdown of the block framer
`include "adx_block_framer_defines.svh"

module adxbf_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data_byte,
	input  logic [7:0]           block_unit_bytes,
	output adxbf_pkg::status_t   status
);

	logic [63:0]     sync_window_q;
	logic            is_locked_q;
	adxbf_pkg::cnt_t frame_len_q;
	adxbf_pkg::cnt_t bytes_left_q;

	logic [63:0]     window_next;
	logic            hdr_hit;
	adxbf_pkg::cnt_t hdr_len;
	logic            lock_now;
	logic [15:0]     frame_prod;
	adxbf_pkg::cnt_t frame_len_new;
	adxbf_pkg::cnt_t first_count;
	adxbf_pkg::cnt_t to_end;
	logic            ends_frame;
	logic            counting;

	always_comb begin
		window_next   = {sync_window_q[55:0], data_byte};
		hdr_hit       = (window_next & adxbf_pkg::HdrMask) == adxbf_pkg::HdrPattern;
		hdr_len       = {1'b0, window_next[47:32]} + adxbf_pkg::HdrLenAdj;
		lock_now      = !is_locked_q && hdr_hit && (data_byte != 8'd0)
			&& (hdr_len >= adxbf_pkg::MinHdrLen);
		frame_prod    = block_unit_bytes * data_byte;
		frame_len_new = {1'b0, frame_prod};
		// first frame runs from header start through one block
		first_count   = hdr_len + frame_len_new - adxbf_pkg::HdrLead;
		if (lock_now) begin
			to_end = first_count;
		end else if (bytes_left_q == '0) begin
			to_end = frame_len_q;
		end else begin
			to_end = bytes_left_q;
		end
		ends_frame = to_end <= adxbf_pkg::cnt_t'(1);
		counting   = is_locked_q || lock_now;
	end

	always_comb begin
		status.frame_last = counting && ends_frame;
		status.locked     = counting;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_window_q <= '0;
			is_locked_q   <= 1'b0;
			frame_len_q   <= '0;
			bytes_left_q  <= '0;
		end else if (step) begin
			// freeze the window once locked
			if (!is_locked_q) begin
				sync_window_q <= window_next;
			end
			if (lock_now) begin
				is_locked_q <= 1'b1;
				frame_len_q <= frame_len_new;
			end
			if (counting) begin
				bytes_left_q <= ends_frame ? '0 : to_end - adxbf_pkg::cnt_t'(1);
			end
		end
	end

	`ADXBF_ASSERT_NEXT(a_lock_holds, is_locked_q, is_locked_q, "framer lost lock")
	`ADXBF_ASSERT_NEXT(a_window_frozen, is_locked_q, $stable(sync_window_q),
		"header window moved after lock")
	`ADXBF_ASSERT_NOW(a_last_needs_lock, step && status.frame_last, status.locked,
		"frame end flagged while unlocked")
	`ADXBF_ASSERT_NEXT(a_countdown, step && is_locked_q && (bytes_left_q > 17'd1),
		bytes_left_q == $past(bytes_left_q) - 17'd1, "frame countdown skipped")
	`ADXBF_ASSERT_NEXT(a_idle_holds, !step,
		$stable(bytes_left_q) && $stable(is_locked_q), "frame state moved without a byte")

endmodule

[design/adx_block_framer.sv]
// Block framer top level: stream stages, configuration port and framing core
//
// Passes a byte stream through unchanged and flags the last byte of every frame.
// Until a header is found, each byte is shifted into an eight-byte window that is
// matched against the fixed header pattern; a match with a nonzero channel count and
// a header length of at least 8 locks the framer. The first frame ends one block
// past the header; every later frame is block_unit_bytes times the channel count.
// block_unit_bytes (APB address 0, reset 18) is sampled at the locking byte only.
// Throughput is one byte per clock with the sink ready. Bytes pass an input stage
// register, then the header compare, channel-count multiply and frame countdown in
// one pass into the output register. The input side stays ready while the output
// register drains, so a stalled sink costs no bubble once it takes the result.
module adx_block_framer (
	input  logic                        clk,
	input  logic                        arst_n,
	adxbf_stream_if.sink                raw,
	adxbf_stream_if.source              framed,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [adxbf_pkg::AddrW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic [7:0]              block_unit_q;
	logic                    valid_s1;
	logic [7:0]              data_s1;
	logic                    out_valid_q;
	adxbf_pkg::framed_item_t out_item_q;
	logic                    advance;
	logic                    step;
	logic                    reg_wr;
	logic                    reg_sel;
	adxbf_pkg::status_t      status;

	// register index is the word address
	assign reg_sel = paddr[adxbf_pkg::AddrW-1] == adxbf_pkg::REG_BLOCK_UNIT;
	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? {24'd0, block_unit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_unit_q <= adxbf_pkg::BlockUnitReset;
		end else if (reg_wr) begin
			block_unit_q <= pwdata[7:0];
		end
	end

	assign advance   = !out_valid_q || framed.ready;
	assign step      = valid_s1 && advance;
	assign raw.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw.ready) begin
			valid_s1 <= raw.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.ready && raw.valid) begin
			data_s1 <= raw.data.data_byte;
		end
	end

	adxbf_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.data_byte        (data_s1),
		.block_unit_bytes (block_unit_q),
		.status           (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_item_q.out_byte   <= data_s1;
			out_item_q.frame_last <= status.frame_last;
			out_item_q.locked     <= status.locked;
		end
	end

	assign framed.valid = out_valid_q;
	assign framed.data  = out_item_q;

endmodule

[tb/sv/adx_block_framer_tb.sv]
// Self-checking testbench for the block framer: header search, lock and frame countdown
module adx_block_framer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RegIdxUnused = 1;  // no register behind this index
	localparam int HoldCycles   = 400;
	localparam int Latency      = 2;
	localparam int IdlePct      = 37;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [adxbf_pkg::AddrW-1:0]    paddr;
	logic [31:0]                    pwdata;
	logic [31:0]                    prdata;
	logic                           pready;

	adxbf_stream_if #(.payload_t(adxbf_pkg::raw_item_t))    raw_ch ();
	adxbf_stream_if #(.payload_t(adxbf_pkg::framed_item_t)) framed_ch ();

	adx_block_framer u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.raw     (raw_ch),
		.framed  (framed_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	// Framer state as the predictor sees it
	logic [63:0]     hdr_window;
	logic            hdr_locked;
	adxbf_pkg::cnt_t frame_size;
	adxbf_pkg::cnt_t bytes_to_go;
	logic [7:0]      unit_cfg;

	adxbf_pkg::framed_item_t expected_frames [$];
	int                      err_cnt;
	bit                      src_gaps;
	bit                      sink_gaps;
	bit                      sink_hold_req;

	// Unlocked stretch with a typed expectation per byte: extremes, a header with
	// zero channels, a header too short, and a header with a wrong fixed byte.
	// out_byte doubles as the byte to send.
	adxbf_pkg::framed_item_t dir_rows [26] = '{
		'{8'h00, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
		'{8'h80, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
		'{8'h10, 1'b0, 1'b0}, '{8'h03, 1'b0, 1'b0}, '{8'h12, 1'b0, 1'b0},
		'{8'h04, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
		'{8'h80, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
		'{8'h03, 1'b0, 1'b0}, '{8'h03, 1'b0, 1'b0}, '{8'h12, 1'b0, 1'b0},
		'{8'h04, 1'b0, 1'b0}, '{8'h05, 1'b0, 1'b0},
		'{8'h80, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
		'{8'hFF, 1'b0, 1'b0}, '{8'h03, 1'b0, 1'b0}, '{8'h12, 1'b0, 1'b0},
		'{8'h05, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0}
	};

	function automatic logic [63:0] adx_header(input logic [15:0] len_field,
		input logic [7:0] chans);
		return adxbf_pkg::HdrPattern | {16'h0, len_field, 24'h0, chans};
	endfunction

	function automatic logic [63:0] broken_header();
		int         fixed_pos [5] = '{7, 6, 3, 2, 1};
		logic [63:0] w;
		int         p;
		case ($urandom_range(0, 2))
			0: w = adx_header(16'($urandom_range(0, 16'hFFFF)), 8'h00);
			1: w = adx_header(16'($urandom_range(0, 3)), 8'($urandom_range(1, 255)));
			default: begin
				w = adx_header(16'($urandom_range(4, 40)), 8'($urandom_range(1, 255)));
				p = fixed_pos[$urandom_range(0, 4)];
				w[p*8 +: 8] = w[p*8 +: 8] ^ 8'($urandom_range(1, 255));
			end
		endcase
		return w;
	endfunction

	// Advance the frame countdown; return 1 when this byte closes the frame
	function automatic logic count_down(input logic [31:0] to_end);
		if (to_end <= 32'd1) begin
			bytes_to_go = '0;
			return 1'b1;
		end
		bytes_to_go = adxbf_pkg::cnt_t'(to_end - 32'd1);
		return 1'b0;
	endfunction

	function automatic adxbf_pkg::framed_item_t frame_step(input logic [7:0] b);
		adxbf_pkg::framed_item_t r;
		logic [31:0]             hdr_len;
		logic [7:0]              chans;
		r.out_byte   = b;
		r.frame_last = 1'b0;
		if (!hdr_locked) begin
			hdr_window = {hdr_window[55:0], b};
			chans      = hdr_window[7:0];
			hdr_len    = 32'(hdr_window[47:32]) + 32'(adxbf_pkg::HdrLenAdj);
			if ((hdr_window & adxbf_pkg::HdrMask) == adxbf_pkg::HdrPattern &&
			    chans != 8'd0 && hdr_len >= 32'(adxbf_pkg::MinHdrLen)) begin
				hdr_locked   = 1'b1;
				frame_size   = adxbf_pkg::cnt_t'(32'(unit_cfg) * 32'(chans));
				// first frame: rest of the header plus one block
				r.frame_last = count_down(hdr_len + 32'(frame_size)
					- 32'(adxbf_pkg::HdrLead));
			end
		end else begin
			r.frame_last = count_down(bytes_to_go == '0 ? 32'(frame_size) : 32'(bytes_to_go));
		end
		r.locked = hdr_locked;
		return r;
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
		input adxbf_pkg::framed_item_t typed_exp = '0);
		adxbf_pkg::framed_item_t predicted;
		if (src_gaps && $urandom_range(0, 99) < IdlePct) begin
			raw_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < IdlePct) @(posedge clk);
		end
		raw_ch.valid          <= 1'b1;
		raw_ch.data.data_byte <= b;
		@(posedge clk);
		while (!raw_ch.ready) @(posedge clk);
		predicted = frame_step(b);
		expected_frames.push_back(typed ? typed_exp : predicted);
	endtask

	task automatic send_word(input logic [63:0] w);
		for (int i = 7; i >= 0; i--) send_byte(w[i*8 +: 8]);
	endtask

	// Unlocked noise mixed with headers that must not lock
	task automatic prelock_chunk(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0) send_word(broken_header());
			else send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Locked traffic; headers here must not restart the search
	task automatic locked_chunk(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_word(adx_header(16'($urandom_range(0, 16'hFFFF)),
					8'($urandom_range(0, 255))));
			else
				send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic drain_frames();
		raw_ch.valid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (Latency + 2) @(posedge clk);
	endtask

	task automatic apb_write(input int reg_sel, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= adxbf_pkg::AddrW'(reg_sel * 4);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (reg_sel == int'(adxbf_pkg::REG_BLOCK_UNIT)) unit_cfg = val[7:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read_check(input int reg_sel, input logic [31:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= adxbf_pkg::AddrW'(reg_sel * 4);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$error("prdata: expected %0h, got %0h", want, prdata);
			err_cnt++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_frame(input adxbf_pkg::framed_item_t got);
		adxbf_pkg::framed_item_t want;
		if (expected_frames.size() == 0) begin
			$error("unexpected transaction: out_byte %0h", got.out_byte);
			err_cnt++;
		end else begin
			want = expected_frames.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
				err_cnt++;
			end
			if (got.frame_last !== want.frame_last) begin
				$error("frame_last: expected %0b, got %0b", want.frame_last, got.frame_last);
				err_cnt++;
			end
			if (got.locked !== want.locked) begin
				$error("locked: expected %0b, got %0b", want.locked, got.locked);
				err_cnt++;
			end
		end
	endtask

	initial begin : sink
		int hold_left;
		bit hold_done;
		hold_left       = 0;
		hold_done       = 1'b0;
		framed_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (framed_ch.valid && framed_ch.ready) check_frame(framed_ch.data);
			if (sink_hold_req && !hold_done) begin
				hold_left = HoldCycles;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				framed_ch.ready <= 1'b0;
			end else begin
				framed_ch.ready <= !(sink_gaps && $urandom_range(0, 99) < IdlePct);
			end
		end
	end

	initial begin : stimulus
		logic [7:0]  lock_unit;
		logic [7:0]  lock_chans;
		logic [15:0] lock_len;
		logic [31:0] scratch;
		arst_n                = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		raw_ch.valid          = 1'b0;
		raw_ch.data           = '0;
		src_gaps              = 1'b1;
		sink_gaps             = 1'b1;
		sink_hold_req         = 1'b0;
		err_cnt               = 0;
		hdr_window            = '0;
		hdr_locked            = 1'b0;
		frame_size            = '0;
		bytes_to_go           = '0;
		unit_cfg              = adxbf_pkg::BlockUnitReset;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_read_check(adxbf_pkg::REG_BLOCK_UNIT, 32'(adxbf_pkg::BlockUnitReset));
		foreach (dir_rows[i]) send_byte(dir_rows[i].out_byte, 1'b1, dir_rows[i]);
		drain_frames();

		// sweep block size extremes while still unlocked
		apb_write(adxbf_pkg::REG_BLOCK_UNIT, 32'd0);
		apb_read_check(adxbf_pkg::REG_BLOCK_UNIT, 32'd0);
		prelock_chunk(30);
		drain_frames();
		apb_write(adxbf_pkg::REG_BLOCK_UNIT, 32'd255);
		apb_read_check(adxbf_pkg::REG_BLOCK_UNIT, 32'd255);
		prelock_chunk(30);
		drain_frames();
		// unmapped index: the write must not land
		scratch = $urandom;
		apb_write(RegIdxUnused, scratch);
		apb_read_check(adxbf_pkg::REG_BLOCK_UNIT, 32'd255);
		apb_write(adxbf_pkg::REG_BLOCK_UNIT, 32'd1);
		apb_read_check(adxbf_pkg::REG_BLOCK_UNIT, 32'd1);
		prelock_chunk(40);
		drain_frames();

		// pick the one lock of the run
		lock_len   = 16'($urandom_range(4, 40));
		lock_chans = 8'($urandom_range(1, 6));
		lock_unit  = 8'($urandom_range(1, 12));
		case ($urandom_range(0, 7))
			0: begin
				// zero block size: every byte after the first frame ends a frame
				lock_unit  = 8'd0;
				lock_chans = 8'($urandom_range(1, 255));
				if ($urandom_range(0, 1) == 0) lock_len = 16'd4;
			end
			1: begin
				lock_unit  = 8'd255;
				lock_chans = 8'd1;
			end
			2: begin
				// shortest header with one-byte frames
				lock_unit  = 8'd1;
				lock_chans = 8'd1;
				lock_len   = 16'd4;
			end
			default: ;
		endcase
		apb_write(adxbf_pkg::REG_BLOCK_UNIT, 32'(lock_unit));
		apb_read_check(adxbf_pkg::REG_BLOCK_UNIT, 32'(lock_unit));
		repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
		send_word(adx_header(lock_len, lock_chans));

		for (int c = 0; c < 12; c++) begin
			if (c % 4 == 1) begin
				// register changes after lock must leave the frame size alone
				drain_frames();
				scratch = 32'($urandom_range(0, 255));
				apb_write(adxbf_pkg::REG_BLOCK_UNIT, scratch);
				apb_read_check(adxbf_pkg::REG_BLOCK_UNIT, scratch);
			end
			if (c == 3) sink_hold_req = 1'b1;
			if (c == 6) begin
				src_gaps  = 1'b0;
				sink_gaps = 1'b0;
			end
			if (c == 8) begin
				src_gaps  = 1'b1;
				sink_gaps = 1'b1;
			end
			locked_chunk(100);
		end
		drain_frames();

		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : watchdog
		#1000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
